FILE: hdl/pioc_pkg.sv
// shared types and constants for the paired interval overlap counter
// no dependencies; imported by paired_interval_overlap_counter_unit
`default_nettype none

package pioc_pkg;

  localparam int unsigned MAX_LOOPS_DEFAULT = 4096;

  localparam int unsigned CHROM_W = 8;
  localparam int unsigned POS_W   = 31;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned COUNT_W = 32;

  localparam logic [POS_W-1:0]   MIN_SPAN_RESET = 31'd1000;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [CHROM_W-1:0] chrom;
    logic [CHROM_W-1:0] chrom_mate;
    logic [POS_W-1:0]   start_a;
    logic [POS_W-1:0]   end_a;
    logic [POS_W-1:0]   start_b;
    logic [POS_W-1:0]   end_b;
    logic [INDEX_W-1:0] entry_index;
  } cmd_t;

  typedef struct packed {
    logic [INDEX_W-1:0] loop_index;
    logic [COUNT_W-1:0] pet_count;
  } rsp_t;

  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   one_lo;
    logic [POS_W-1:0]   one_hi;
    logic [POS_W-1:0]   two_lo;
    logic [POS_W-1:0]   two_hi;
  } loop_entry_t;

endpackage

`default_nettype wire

FILE: hdl/paired_interval_overlap_counter_unit.sv
// paired interval overlap counter: loop table, tag pair walk and count read-out
// depends on pioc_pkg for the transaction structs, loop entry layout and constants
`default_nettype none

// A load or a read transaction leaves busy low. A read answers on result with a
// one-cycle done strobe in the cycle after acceptance, and the receiver cannot
// stall it. A count transaction whose chromosomes match holds busy through the
// midpoint arithmetic and separation check states (ST_HALF, ST_MID, ST_SEP); if
// the midpoint separation reaches min_span it then walks the loop table one entry
// per cycle through the single read port of the loop memory, ending early when
// the walk meets the first anchor group that starts past end_a. Counts are updated
// read-modify-write in a separate count memory, one entry behind the walk. A count
// with mismatched chromosomes, and an unknown action, are absorbed without raising
// busy. No clearing pass is needed after reset.
module paired_interval_overlap_counter_unit #(
  parameter int unsigned MAX_LOOPS = pioc_pkg::MAX_LOOPS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire pioc_pkg::cmd_t                cmd,
  input  wire logic                          cfg_we,
  input  wire logic [pioc_pkg::POS_W-1:0]    cfg_wdata,
  output logic                               done,
  output pioc_pkg::rsp_t                     result
);

  import pioc_pkg::*;

  localparam int unsigned AW    = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LOOPS + 1);
  localparam int unsigned ZW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HALF = 5'b00010,
    ST_MID  = 5'b00100,
    ST_SEP  = 5'b01000,
    ST_WALK = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [POS_W-1:0]   min_span;
  logic [CNT_W-1:0]   entries_loaded;

  // tag pair under test
  logic [CHROM_W-1:0] t_chrom;
  logic [POS_W-1:0]   t_sa, t_ea, t_sb, t_eb;

  // midpoint arithmetic
  logic [31:0]        half_a, half_b;
  logic               fix_a, fix_b;
  logic [31:0]        mid_a, mid_b;
  logic [31:0]        diff_a, diff_b;
  logic [33:0]        sep_margin;

  // walk
  logic [CNT_W-1:0]   ptr;
  logic               rd_vld;
  logic [AW-1:0]      rd_addr_q;
  logic               have_prev;
  logic [POS_W-1:0]   prev_lo, prev_hi;
  logic               group_done;

  // memories
  loop_entry_t        loop_mem [MAX_LOOPS];
  logic [COUNT_W-1:0] cnt_mem  [MAX_LOOPS];
  loop_entry_t        loop_q;
  logic [COUNT_W-1:0] cnt_q;

  // read response
  logic               rsp_pending;
  logic               rsp_in_range;
  logic [INDEX_W-1:0] rsp_idx;

  logic               accept;
  logic               load_we;
  logic               read_acc;
  logic               count_acc;
  logic [ZW-1:0]      idx_z;
  logic               idx_in_range;
  logic               issue;
  logic               walk_end;
  loop_entry_t        load_entry;

  logic               chrom_hit, new_grp, below, past;
  logic               stop_now, eff_done, consider, take, hit, hit_we;

  logic               cnt_we, cnt_re;
  logic [AW-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_W-1:0] cnt_wdata;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load_we   = accept && (cmd.action == ACT_LOAD) &&
                     (entries_loaded != CNT_W'(MAX_LOOPS));
  assign read_acc  = accept && (cmd.action == ACT_READ);
  assign count_acc = accept && (cmd.action == ACT_COUNT) && (cmd.chrom == cmd.chrom_mate);

  assign idx_z        = ZW'(cmd.entry_index);
  assign idx_in_range = idx_z < ZW'(entries_loaded);

  assign load_entry.chrom  = cmd.chrom;
  assign load_entry.one_lo = cmd.start_a;
  assign load_entry.one_hi = cmd.end_a;
  assign load_entry.two_lo = cmd.start_b;
  assign load_entry.two_hi = cmd.end_b;

  // midpoint halves truncate toward zero: arithmetic shift plus one for negative odd
  assign diff_a = {1'b0, t_ea} - {1'b0, t_sa};
  assign diff_b = {1'b0, t_eb} - {1'b0, t_sb};
  assign sep_margin = {2'b00, mid_b} - {2'b00, mid_a} - {3'b000, min_span};

  // per-entry walk decision on the loop memory output
  always_comb begin
    chrom_hit = (loop_q.chrom == t_chrom);
    new_grp   = !have_prev || (loop_q.one_lo != prev_lo) || (loop_q.one_hi != prev_hi);
    below     = loop_q.one_hi < t_sa;
    past      = loop_q.one_lo > t_ea;
    stop_now  = (state == ST_WALK) && rd_vld && chrom_hit && new_grp && !below && past;
    eff_done  = new_grp ? below : group_done;
    consider  = (state == ST_WALK) && rd_vld && chrom_hit && !(new_grp && past) && !eff_done;
    take      = consider && (loop_q.two_hi >= t_sb);
    hit       = take && (loop_q.two_lo <= t_eb);
    hit_we    = hit && (cnt_q != COUNT_MAX);
  end

  assign issue    = (state == ST_WALK) && (ptr != entries_loaded) && !stop_now;
  assign walk_end = stop_now || ((ptr == entries_loaded) && !rd_vld);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (count_acc) state_next = ST_HALF;
      end
      ST_HALF: state_next = ST_MID;
      ST_MID:  state_next = ST_SEP;
      ST_SEP: begin
        state_next = sep_margin[33] ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      min_span       <= MIN_SPAN_RESET;
      entries_loaded <= '0;
      rd_vld         <= 1'b0;
      rsp_pending    <= 1'b0;
    end else begin
      state       <= state_next;
      rd_vld      <= issue;
      rsp_pending <= read_acc;
      if (cfg_we) min_span <= cfg_wdata;
      if (load_we) entries_loaded <= entries_loaded + CNT_W'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (count_acc) begin
      t_chrom <= cmd.chrom;
      t_sa    <= cmd.start_a;
      t_ea    <= cmd.end_a;
      t_sb    <= cmd.start_b;
      t_eb    <= cmd.end_b;
    end
    if (read_acc) begin
      rsp_idx      <= cmd.entry_index;
      rsp_in_range <= idx_in_range;
    end
    if (state == ST_HALF) begin
      half_a <= {diff_a[31], diff_a[31:1]};
      half_b <= {diff_b[31], diff_b[31:1]};
      fix_a  <= diff_a[31] & diff_a[0];
      fix_b  <= diff_b[31] & diff_b[0];
    end
    if (state == ST_MID) begin
      mid_a <= {1'b0, t_sa} + half_a + {31'b0, fix_a};
      mid_b <= {1'b0, t_sb} + half_b + {31'b0, fix_b};
    end
    if (state == ST_SEP) begin
      ptr        <= '0;
      have_prev  <= 1'b0;
      group_done <= 1'b0;
    end
    if (issue) begin
      ptr       <= ptr + CNT_W'(1);
      rd_addr_q <= ptr[AW-1:0];
    end
    if ((state == ST_WALK) && rd_vld && chrom_hit) begin
      if (new_grp) begin
        have_prev <= 1'b1;
        prev_lo   <= loop_q.one_lo;
        prev_hi   <= loop_q.one_hi;
      end
      group_done <= take | eff_done;
    end
  end

  // loop table memory
  always_ff @(posedge clk) begin
    if (load_we) loop_mem[entries_loaded[AW-1:0]] <= load_entry;
    if (issue) loop_q <= loop_mem[ptr[AW-1:0]];
  end

  // count memory: cleared on load, bumped one entry behind the walk
  assign cnt_we    = load_we | hit_we;
  assign cnt_waddr = load_we ? entries_loaded[AW-1:0] : rd_addr_q;
  assign cnt_wdata = load_we ? '0 : cnt_q + COUNT_W'(1);
  assign cnt_re    = issue | read_acc;
  assign cnt_raddr = issue ? ptr[AW-1:0] : idx_z[AW-1:0];

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_q <= cnt_mem[cnt_raddr];
  end

  assign done              = rsp_pending;
  assign result.loop_index = rsp_idx;
  assign result.pet_count  = rsp_in_range ? cnt_q : '0;

endmodule

`default_nettype wire

FILE: test/paired_interval_overlap_counter_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for paired_interval_overlap_counter_unit: loop loads, tag pair
// counts and count reads checked against a behavioural loop table kept in the bench
// depends on pioc_pkg and the rtl of the unit; needs nothing else

module paired_interval_overlap_counter_unit_tb;
  import pioc_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_LOOPS_DEFAULT;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  cmd_t                 cmd;
  logic                 cfg_we;
  logic [POS_W-1:0]     cfg_wdata;
  logic                 done;
  rsp_t                 result;

  // behavioural copy of the loop table
  loop_entry_t          loop_tab [TABLE_DEPTH];
  logic [COUNT_W-1:0]   hits [TABLE_DEPTH];
  int unsigned          n_loops;
  logic [POS_W-1:0]     span_cfg;
  rsp_t                 count_answers[$];

  // stimulus side
  cmd_t                 pending_cmds[$];
  loop_entry_t          batch_q[$];
  int unsigned          planned_loads;
  int unsigned          batch_base;
  int                   gap_left;
  bit                   gap_mode;
  int                   errors;

  paired_interval_overlap_counter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  function automatic longint midpoint_of(logic [POS_W-1:0] s, logic [POS_W-1:0] e);
    longint ls;
    longint le;
    ls = longint'({33'd0, s});
    le = longint'({33'd0, e});
    return ls + (le - ls) / 2;
  endfunction

  // walk the table as the hardware does: one candidate per first-anchor group
  function automatic void tally_pair(cmd_t c);
    bit               have_grp;
    bit               grp_closed;
    logic [POS_W-1:0] g_lo;
    logic [POS_W-1:0] g_hi;
    have_grp   = 1'b0;
    grp_closed = 1'b0;
    g_lo       = '0;
    g_hi       = '0;
    for (int i = 0; i < n_loops; i++) begin
      if (loop_tab[i].chrom != c.chrom) continue;
      if (!have_grp || loop_tab[i].one_lo != g_lo || loop_tab[i].one_hi != g_hi) begin
        have_grp = 1'b1;
        g_lo     = loop_tab[i].one_lo;
        g_hi     = loop_tab[i].one_hi;
        if (loop_tab[i].one_hi < c.start_a) begin
          grp_closed = 1'b1;
          continue;
        end
        if (loop_tab[i].one_lo > c.end_a) return;
        grp_closed = 1'b0;
      end
      if (grp_closed) continue;
      if (loop_tab[i].two_hi < c.start_b) continue;
      if (loop_tab[i].two_lo <= c.end_b && hits[i] != COUNT_MAX) hits[i] = hits[i] + 1'b1;
      grp_closed = 1'b1;
    end
  endfunction

  function automatic void process_command(cmd_t c);
    rsp_t r;
    case (c.action)
      ACT_LOAD: begin
        if (n_loops < TABLE_DEPTH) begin
          loop_tab[n_loops].chrom  = c.chrom;
          loop_tab[n_loops].one_lo = c.start_a;
          loop_tab[n_loops].one_hi = c.end_a;
          loop_tab[n_loops].two_lo = c.start_b;
          loop_tab[n_loops].two_hi = c.end_b;
          hits[n_loops]            = '0;
          n_loops++;
        end
      end
      ACT_COUNT: begin
        if (c.chrom == c.chrom_mate &&
            midpoint_of(c.start_b, c.end_b) - midpoint_of(c.start_a, c.end_a) >=
            longint'({33'd0, span_cfg}))
          tally_pair(c);
      end
      ACT_READ: begin
        r.loop_index = c.entry_index;
        r.pet_count  = (c.entry_index < n_loops) ? hits[c.entry_index] : '0;
        count_answers = {count_answers, r};
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gap_mode || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // driver: one transaction offered at a time, held until busy is low
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      cmd      <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) process_command(cmd);
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd      <= pending_cmds.pop_front();
          start    <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done strobe must match the oldest outstanding read
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (count_answers.size() == 0) begin
        report_mismatch("read answer with no read outstanding");
      end else begin
        want = count_answers.pop_front();
        if (result.loop_index !== want.loop_index)
          report_mismatch($sformatf("loop_index %0d, wanted %0d",
                                    result.loop_index, want.loop_index));
        if (result.pet_count !== want.pet_count)
          report_mismatch($sformatf("pet_count %0d for entry %0d, wanted %0d",
                                    result.pet_count, want.loop_index, want.pet_count));
      end
    end
  end

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.action      = 2'($urandom);
    c.chrom       = 8'($urandom);
    c.chrom_mate  = 8'($urandom);
    c.start_a     = 31'($urandom);
    c.end_a       = 31'($urandom);
    c.start_b     = 31'($urandom);
    c.end_b       = 31'($urandom);
    c.entry_index = 12'($urandom);
    return c;
  endfunction

  task automatic push_load(loop_entry_t e);
    cmd_t c;
    c         = noise_cmd();
    c.action  = ACT_LOAD;
    c.chrom   = e.chrom;
    c.start_a = e.one_lo;
    c.end_a   = e.one_hi;
    c.start_b = e.two_lo;
    c.end_b   = e.two_hi;
    pending_cmds = {pending_cmds, c};
    if (planned_loads < TABLE_DEPTH) planned_loads++;
  endtask

  task automatic push_pair(logic [CHROM_W-1:0] chr, int unsigned sa, int unsigned ea,
                           int unsigned sb, int unsigned eb);
    cmd_t c;
    c            = noise_cmd();
    c.action     = ACT_COUNT;
    c.chrom      = chr;
    c.chrom_mate = chr;
    c.start_a    = sa[POS_W-1:0];
    c.end_a      = ea[POS_W-1:0];
    c.start_b    = sb[POS_W-1:0];
    c.end_b      = eb[POS_W-1:0];
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic push_read(int unsigned idx);
    cmd_t c;
    c             = noise_cmd();
    c.action      = ACT_READ;
    c.entry_index = idx[INDEX_W-1:0];
    pending_cmds  = {pending_cmds, c};
  endtask

  task automatic push_entry(logic [CHROM_W-1:0] chr, int unsigned a_lo, int unsigned a_hi,
                            int unsigned b_lo, int unsigned b_hi);
    loop_entry_t e;
    e.chrom  = chr;
    e.one_lo = a_lo[POS_W-1:0];
    e.one_hi = a_hi[POS_W-1:0];
    e.two_lo = b_lo[POS_W-1:0];
    e.two_hi = b_hi[POS_W-1:0];
    push_load(e);
  endtask

  // sorted run of loops on one chromosome, groups of one to three sharing anchor one
  task automatic load_batch(logic [CHROM_W-1:0] chr, int n);
    loop_entry_t e;
    int unsigned pos;
    int unsigned base;
    int          k;
    batch_q.delete();
    batch_base = planned_loads;
    pos        = $urandom_range(0, 1_000_000);
    while (batch_q.size() < n) begin
      e.chrom  = chr;
      e.one_lo = pos[POS_W-1:0];
      e.one_hi = POS_W'(pos + $urandom_range(0, 2000));
      k        = $urandom_range(1, 3);
      base     = e.one_hi + $urandom_range(0, 60000);
      for (int j = 0; j < k && batch_q.size() < n; j++) begin
        e.two_lo = base[POS_W-1:0];
        e.two_hi = POS_W'(base + $urandom_range(0, 3000));
        batch_q  = {batch_q, e};
        push_load(e);
        base = base + $urandom_range(0, 3000);
      end
      pos = pos + $urandom_range(1, 3000);
    end
  endtask

  // mostly pairs aimed at loaded loops, the rest near misses, reads and noise
  task automatic mixed_traffic(int n);
    loop_entry_t e;
    cmd_t        c;
    int unsigned r;
    int unsigned sa;
    int unsigned sb;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      e  = batch_q[$urandom_range(0, batch_q.size() - 1)];
      sa = $urandom_range(e.one_lo, e.one_hi);
      sb = $urandom_range(e.two_lo, e.two_hi);
      if (r < 55) begin
        push_pair(e.chrom, sa, sa + $urandom_range(0, 300), sb, sb + $urandom_range(0, 300));
      end else if (r < 65) begin
        if (r[0]) sa = e.one_hi + $urandom_range(1, 500);
        else if (e.two_lo > 600) sb = e.two_lo - $urandom_range(1, 600);
        push_pair(e.chrom, sa, sa + $urandom_range(0, 300), sb, sb + $urandom_range(0, 300));
      end else if (r < 80) begin
        if ($urandom_range(0, 99) < 85) push_read($urandom_range(0, planned_loads));
        else push_read($urandom_range(0, 4095));
      end else if (r < 88) begin
        c        = noise_cmd();
        c.action = ACT_COUNT;
        if (r[0]) c.chrom_mate = c.chrom;
        pending_cmds = {pending_cmds, c};
      end else if (r < 93) begin
        // ends swapped: negative separation
        push_pair(e.chrom, sb, sb + $urandom_range(0, 300), sa, sa + $urandom_range(0, 300));
      end else if (r < 97) begin
        c            = noise_cmd();
        c.action     = ACT_COUNT;
        c.chrom      = e.chrom;
        c.chrom_mate = e.chrom ^ 8'($urandom_range(1, 255));
        c.start_a    = sa[POS_W-1:0];
        c.end_a      = sa[POS_W-1:0];
        c.start_b    = sb[POS_W-1:0];
        c.end_b      = sb[POS_W-1:0];
        pending_cmds = {pending_cmds, c};
      end else begin
        c        = noise_cmd();
        c.action = 2'd3;
        pending_cmds = {pending_cmds, c};
      end
    end
  endtask

  // drain until nothing is queued or offered and busy is low, then keep idling past any last read answer
  task automatic wait_idle();
    do @(negedge clk); while (pending_cmds.size() != 0 || start || busy);
    repeat (n_loops + 16) @(negedge clk);
  endtask

  task automatic write_span(logic [POS_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    span_cfg  = v;
    @(negedge clk);
  endtask

  initial begin
    logic [POS_W-1:0] spans [4];
    logic [CHROM_W-1:0] chroms [4];
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    span_cfg      = MIN_SPAN_RESET;
    n_loops       = 0;
    planned_loads = 0;
    errors        = 0;
    gap_left      = 0;
    gap_mode      = 1'b1;
    spans         = '{31'd0, 31'h7FFF_FFFF, 31'd30000, MIN_SPAN_RESET};
    chroms        = '{8'd17, 8'd90, 8'd163, 8'd236};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset span
    push_read(0);
    push_entry(8'd0, 0, 100, 1000, 3000);
    push_entry(8'd0, 0, 100, 5000, 6000);
    push_entry(8'd0, 200, 300, 8000, 9000);
    push_entry(8'd255, 1000, 2000, 2147480000, 2147483647);
    push_pair(8'd0, 10, 20, 2500, 2600);
    push_pair(8'd0, 10, 20, 5500, 5600);
    push_pair(8'd0, 0, 0, 1000, 1000);
    push_pair(8'd0, 0, 0, 999, 999);
    push_pair(8'd0, 250, 260, 8500, 8500);
    push_pair(8'd0, 10, 20, 4000, 4500);
    push_pair(8'd0, 2500, 2600, 10, 20);
    push_pair(8'd0, 90, 10, 2600, 2400);
    push_pair(8'd255, 1500, 1500, 2147483647, 2147483647);
    push_pair(8'd0, 0, 2147483647, 2147483647, 2147483647);
    begin
      cmd_t c;
      c            = noise_cmd();
      c.action     = ACT_COUNT;
      c.chrom      = 8'd0;
      c.chrom_mate = 8'd1;
      c.start_a    = 31'd10;
      c.end_a      = 31'd20;
      c.start_b    = 31'd2500;
      c.end_b      = 31'd2600;
      pending_cmds = {pending_cmds, c};
      c            = noise_cmd();
      c.action     = 2'd3;
      pending_cmds = {pending_cmds, c};
    end
    for (int i = 0; i <= 4; i++) push_read(i);
    push_read(4095);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      gap_mode = (p != 1);
      write_span(spans[p]);
      load_batch(chroms[p], 8);
      mixed_traffic(14);
      // the widest span only passes a pair from the very bottom to the very top
      if (p == 1) push_pair(chroms[p], 0, 0, 2147483647, 2147483647);
      for (int i = 0; i < 8; i++) push_read(batch_base + i);
      wait_idle();
    end

    while (count_answers.size() != 0) begin
      report_mismatch($sformatf("no answer for read of entry %0d",
                                count_answers[0].loop_index));
      void'(count_answers.pop_front());
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/pioc_pkg.sv
hdl/paired_interval_overlap_counter_unit.sv
test/paired_interval_overlap_counter_unit_tb.sv
